// ----- rtl/sfd_pkg.sv -----
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int CHAR_BITS     = 9;
    localparam int BYTE_W        = 8;
    localparam int CHAN_W        = 11;
    localparam int INDEX_W       = 4;
    localparam int POS_W         = 5;
    localparam int CHANNEL_BYTES = 22;
    localparam int CHANNEL_COUNT = 16;
    localparam int FRAME_W       = CHANNEL_BYTES * BYTE_W;

    localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'h0F;
    localparam logic [BYTE_W-1:0] FOOTER_BYTE  = 8'h00;
    localparam logic [CHAN_W-1:0] CHANNEL_MASK = 11'h7FF;

    localparam logic [POS_W-1:0] POS_HEADER    = 5'd0;
    localparam logic [POS_W-1:0] POS_LAST_DATA = 5'd22;
    localparam logic [POS_W-1:0] POS_FOOTER    = 5'd24;

    typedef logic [CHAR_BITS-1:0] line_t;
    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [INDEX_W-1:0]   index_t;

    typedef struct packed {
        logic  load;
        logic  start;
        byte_t data;
    } ctrl_t;

endpackage

// ----- rtl/sfd_char_if.sv -----
`timescale 1ns / 1ps

interface sfd_char_if;
    logic           valid;
    logic           ready;
    sfd_pkg::line_t line_bits;

    modport source (output valid, output line_bits, input ready);
    modport sink   (input valid, input line_bits, output ready);
endinterface

// ----- rtl/sfd_chan_if.sv -----
`timescale 1ns / 1ps

interface sfd_chan_if;
    logic            valid;
    logic            ready;
    sfd_pkg::index_t channel_index;
    sfd_pkg::chan_t  channel_value;
    logic            last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last_channel, output ready);
endinterface

// ----- rtl/sbus_frame_decoder_unit.sv -----
`timescale 1ns / 1ps
// Header, channel, flags and bad characters are each taken as they arrive; a new
// character is taken whenever the unpacker is not busy.
// A good footer starts the unpack shift register: the first channel word is
// offered the cycle after, then one word per cycle while the channel side is
// ready; no character is taken until channel fifteen is taken.
// Reset returns the decoder to waiting for a header with no word pending.

module sbus_frame_decoder_unit (
    input  logic   clk,
    input  logic   rst_n,
    sfd_char_if.sink   chars,
    sfd_chan_if.source channels
);
    import sfd_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             accept;
    logic             parity_bad;
    byte_t            data;
    ctrl_t            ctrl;
    logic             busy;

    assign accept     = chars.valid && chars.ready;
    assign parity_bad = ~(^chars.line_bits);
    assign data       = ~chars.line_bits[BYTE_W-1:0];

    always_comb
    begin
        pos_next   = pos_reg;
        ctrl.load  = 1'b0;
        ctrl.start = 1'b0;
        ctrl.data  = data;
        if (accept)
        begin
            if (parity_bad)
            begin
                pos_next = POS_HEADER;
            end
            else if (pos_reg == POS_HEADER)
            begin
                if (data == HEADER_BYTE)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            else if (pos_reg < POS_FOOTER)
            begin
                ctrl.load = (pos_reg <= POS_LAST_DATA);
                pos_next  = pos_reg + 1'b1;
            end
            else
            begin
                pos_next   = POS_HEADER;
                ctrl.start = (data == FOOTER_BYTE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HEADER;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign chars.ready = !busy;

    sfd_unpacker u_unpacker (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .busy     (busy),
        .channels (channels)
    );

endmodule

// ----- rtl/sfd_unpacker.sv -----
`timescale 1ns / 1ps

module sfd_unpacker (
    input  logic           clk,
    input  logic           rst_n,
    input  sfd_pkg::ctrl_t ctrl,
    output logic           busy,
    sfd_chan_if.source     channels
);
    import sfd_pkg::*;

    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_next;
    index_t             cnt_reg;
    index_t             cnt_next;
    logic               busy_reg;
    logic               busy_next;
    logic               last;
    logic               take;

    assign last = (cnt_reg == INDEX_W'(CHANNEL_COUNT - 1));
    assign take = busy_reg && channels.ready;

    always_comb
    begin
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (ctrl.load)
        begin
            frame_next = {ctrl.data, frame_reg[FRAME_W-1:BYTE_W]};
        end
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        if (take)
        begin
            // advance to the next packed channel
            frame_next = {{CHAN_W{1'b0}}, frame_reg[FRAME_W-1:CHAN_W]};
            cnt_next   = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy                   = busy_reg;
    assign channels.valid         = busy_reg;
    assign channels.channel_index = cnt_reg;
    assign channels.channel_value = frame_reg[CHAN_W-1:0] & CHANNEL_MASK;
    assign channels.last_channel  = last;

endmodule

// ----- tb/sv/sbus_frame_decoder_unit_tb.sv -----
`timescale 1ns / 1ps

module sbus_frame_decoder_unit_tb;
    import sfd_pkg::*;

    localparam int FRAME_CHARS = CHANNEL_BYTES + 3;
    localparam int RANDOM_CHARS = 150;
    localparam int SETTLE_CYCLES = 50;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_FILL} row_kind_e;
    typedef enum logic [1:0] {FLOW_OPEN, FLOW_COIN, FLOW_ALTERNATE, FLOW_CHOKE} flow_e;

    typedef struct {
        line_t     line;
        row_kind_e kind;
        chan_t     fill;
    } step_t;

    typedef struct {
        index_t idx;
        chan_t  value;
        logic   last;
    } chan_word_t;

    logic clk;
    logic rst_n;

    sfd_char_if char_bus ();
    sfd_chan_if chan_bus ();

    sbus_frame_decoder_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (char_bus),
        .channels (chan_bus)
    );

    logic [POS_W-1:0] frame_pos;
    byte_t            frame_buf [CHANNEL_BYTES];
    chan_t            unpacked [CHANNEL_COUNT];
    chan_word_t       pending_channels[$];

    int    bad_words;
    int    burst_left;
    int    flow_left;
    flow_e flow;

    always #5 clk = ~clk;

    function automatic line_t enc(byte_t b);
        return {~(^b), ~b};
    endfunction

    function automatic logic decode_char(line_t c);
        byte_t                data;
        logic [FRAME_W-1:0]   flat;
        int                   k;
        if (((CHAR_BITS - $countones(c)) % 2) == 1)
        begin
            frame_pos = POS_HEADER;
            return 1'b0;
        end
        data = ~c[BYTE_W-1:0];
        if (frame_pos == POS_HEADER)
        begin
            if (data == HEADER_BYTE)
                frame_pos = POS_HEADER + 1'b1;
            return 1'b0;
        end
        if (frame_pos < POS_FOOTER)
        begin
            if (frame_pos <= POS_LAST_DATA)
                frame_buf[frame_pos - 1'b1] = data;
            frame_pos = frame_pos + 1'b1;
            return 1'b0;
        end
        frame_pos = POS_HEADER;
        if (data != FOOTER_BYTE)
            return 1'b0;
        for (k = 0; k < CHANNEL_BYTES; k++)
            flat[BYTE_W*k +: BYTE_W] = frame_buf[k];
        for (k = 0; k < CHANNEL_COUNT; k++)
            unpacked[k] = flat[CHAN_W*k +: CHAN_W];
        return 1'b1;
    endfunction

    task automatic send_char(line_t c, row_kind_e kind, chan_t fill);
        chan_word_t w;
        logic       done;
        int         i;
        if (burst_left == 0)
        begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        char_bus.valid     <= 1'b1;
        char_bus.line_bits <= c;
        do @(posedge clk); while (!char_bus.ready);
        burst_left--;
        done = decode_char(c);
        if ((kind == ROW_FILL) || ((kind == ROW_PREDICT) && done))
        begin
            for (i = 0; i < CHANNEL_COUNT; i++)
            begin
                w.idx   = index_t'(i);
                w.value = (kind == ROW_FILL) ? fill : unpacked[i];
                w.last  = (i == CHANNEL_COUNT - 1);
                pending_channels.push_back(w);
            end
        end
    endtask

    function automatic void note_bad(string msg);
        bad_words++;
        if (bad_words <= 10)
            $display("%s", msg);
    endfunction

    // stall the channel side in phases of varying pressure
    always @(posedge clk)
    begin
        if (flow_left == 0)
        begin
            flow      = flow_e'($urandom_range(0, 3));
            flow_left = $urandom_range(4, 64);
        end
        flow_left--;
        case (flow)
            FLOW_OPEN:      chan_bus.ready <= 1'b1;
            FLOW_COIN:      chan_bus.ready <= $urandom_range(0, 1);
            FLOW_ALTERNATE: chan_bus.ready <= (flow_left % 2 == 0);
            default:        chan_bus.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        chan_word_t want;
        if (rst_n && chan_bus.valid && chan_bus.ready)
        begin
            if (pending_channels.size() == 0)
            begin
                note_bad($sformatf("unexpected word: index %0d value 0x%03h last %0b",
                                   chan_bus.channel_index, chan_bus.channel_value,
                                   chan_bus.last_channel));
            end
            else
            begin
                want = pending_channels.pop_front();
                if (chan_bus.channel_index !== want.idx ||
                    chan_bus.channel_value !== want.value ||
                    chan_bus.last_channel !== want.last)
                begin
                    note_bad($sformatf(
                        "mismatch: expected index %0d value 0x%03h last %0b, got %0d 0x%03h %0b",
                        want.idx, want.value, want.last, chan_bus.channel_index,
                        chan_bus.channel_value, chan_bus.last_channel));
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[sbus_frame_decoder_unit] ERROR");
        $finish;
    end

    initial
    begin
        step_t script[$];
        line_t frame_chars [FRAME_CHARS];
        int    i;
        int    pick;
        int    sent;

        clk                = 1'b0;
        rst_n              = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.line_bits = '0;
        chan_bus.ready     = 1'b0;
        frame_pos          = POS_HEADER;
        bad_words          = 0;
        burst_left         = 0;
        flow_left          = 0;
        flow               = FLOW_OPEN;
        for (i = 0; i < CHANNEL_BYTES; i++)
            frame_buf[i] = '0;

        // idle line is no header; all-low line is a parity error
        script.push_back(step_t'{9'h1FF, ROW_QUIET, '0});
        script.push_back(step_t'{9'h000, ROW_QUIET, '0});
        script.push_back(step_t'{enc(HEADER_BYTE), ROW_QUIET, '0});
        for (i = 0; i < CHANNEL_BYTES; i++)
            script.push_back(step_t'{enc(8'h00), ROW_QUIET, '0});
        script.push_back(step_t'{enc(8'hFF), ROW_QUIET, '0});
        script.push_back(step_t'{enc(FOOTER_BYTE), ROW_FILL, 11'h000});
        script.push_back(step_t'{enc(HEADER_BYTE), ROW_QUIET, '0});
        for (i = 0; i < CHANNEL_BYTES; i++)
            script.push_back(step_t'{enc(8'hFF), ROW_QUIET, '0});
        script.push_back(step_t'{enc(8'h00), ROW_QUIET, '0});
        script.push_back(step_t'{enc(FOOTER_BYTE), ROW_FILL, CHANNEL_MASK});
        // drop a frame on a parity error mid-frame
        script.push_back(step_t'{enc(HEADER_BYTE), ROW_PREDICT, '0});
        for (i = 0; i < 3; i++)
            script.push_back(step_t'{enc(8'hA5), ROW_PREDICT, '0});
        script.push_back(step_t'{9'h0FF, ROW_QUIET, '0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_char(script[i].line, script[i].kind, script[i].fill);

        sent = 0;
        while (sent < RANDOM_CHARS)
        begin
            pick = $urandom_range(0, 9);
            if (pick >= 8)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_char((pick == 8) ? line_t'($urandom) : enc(byte_t'($urandom)),
                              ROW_PREDICT, '0);
                    sent++;
                end
            end
            else
            begin
                frame_chars[0] = enc(HEADER_BYTE);
                for (i = 1; i <= CHANNEL_BYTES + 1; i++)
                    frame_chars[i] = enc(byte_t'($urandom));
                frame_chars[FRAME_CHARS-1] = enc(FOOTER_BYTE);
                if (pick == 6)
                    frame_chars[FRAME_CHARS-1] = enc(byte_t'($urandom_range(1, 255)));
                if (pick == 7)
                    frame_chars[$urandom_range(0, FRAME_CHARS-1)] ^=
                        line_t'(1) << $urandom_range(0, CHAR_BITS-1);
                for (i = 0; i < FRAME_CHARS; i++)
                begin
                    send_char(frame_chars[i], ROW_PREDICT, '0);
                    sent++;
                end
            end
        end
        char_bus.valid <= 1'b0;

        while (pending_channels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (bad_words == 0)
            $display("[sbus_frame_decoder_unit] OK");
        else
            $display("[sbus_frame_decoder_unit] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sfd_pkg.sv
rtl/sfd_char_if.sv
rtl/sfd_chan_if.sv
rtl/sfd_unpacker.sv
rtl/sbus_frame_decoder_unit.sv
tb/sv/sbus_frame_decoder_unit_tb.sv
